@@ design/bvre_pkg.sv @@
// ============================================================================
// Bit vector range engine package
// Shared operation codes, controller states, command and status groups, and
// the small byte-level helper functions used by the datapath.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package bvre_pkg;

    typedef enum logic [2:0] {
        OP_READ     = 3'd0,
        OP_SET      = 3'd1,
        OP_FLIP     = 3'd2,
        OP_COUNT    = 3'd3,
        OP_CONTAINS = 3'd4,
        OP_FIRST    = 3'd5,
        OP_LAST     = 3'd6,
        OP_FILL     = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_START,
        ST_WALK,
        ST_FILL,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic load;
        logic sweep;
        logic walk;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic is_fill;
        logic skip;
        logic walk_done;
    } dp_stat_t;

    // Bit position k counts from the most significant bit of a byte.
    function automatic logic [7:0] range_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] m;
        m = '0;
        for (int k = 0; k < 8; k++)
        begin
            if ((3'(k) >= lo) && (3'(k) <= hi))
            begin
                m[7 - k] = 1'b1;
            end
        end
        return m;
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] m);
        logic [3:0] c;
        c = '0;
        for (int k = 0; k < 8; k++)
        begin
            c = c + 4'(m[k]);
        end
        return c;
    endfunction

    function automatic logic [2:0] first_pos(input logic [7:0] m);
        logic [2:0] p;
        p = '0;
        for (int k = 7; k >= 0; k--)
        begin
            if (m[7 - k])
            begin
                p = 3'(k);
            end
        end
        return p;
    endfunction

    function automatic logic [2:0] last_pos(input logic [7:0] m);
        logic [2:0] p;
        p = '0;
        for (int k = 0; k < 8; k++)
        begin
            if (m[7 - k])
            begin
                p = 3'(k);
            end
        end
        return p;
    endfunction

endpackage

`default_nettype wire

@@ design/bit_vector_range_engine_unit.sv @@
// A fill writes every byte of the store, one byte a cycle.
// The engine takes one item at a time; its byte walk reads the store one byte a cycle.
// After reset a clearing pass zeroes the store while input stalls.
// ============================================================================
// Bit vector range engine
// Byte-organized bit store with read, range set and flip, count, contains,
// first and last search, and fill, one result item per request item.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bit_vector_range_engine_unit #(
    parameter int STORE_BITS = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  op,
    input  wire logic [9:0]  start_req,
    input  wire logic [10:0] length,
    input  wire logic        bit_value,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             bit_read,
    output logic [10:0]      count,
    output logic [9:0]       index,
    output logic             found,
    output logic             range_error
);
    import bvre_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    bvre_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    bvre_datapath #(
        .STORE_BITS (STORE_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .start_req   (start_req),
        .length      (length),
        .bit_value   (bit_value),
        .cmd         (cmd),
        .stat        (stat),
        .bit_read    (bit_read),
        .count       (count),
        .index       (index),
        .found       (found),
        .range_error (range_error)
    );

endmodule

`default_nettype wire

@@ design/bvre_ctrl.sv @@
// ============================================================================
// Bit vector range engine controller
// Sequences the reset clearing pass, request decode, the byte walk, the fill
// sweep and the hand-off of each result into the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bvre_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output bvre_pkg::dp_cmd_t       cmd,
    input  wire bvre_pkg::dp_stat_t stat
);
    import bvre_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                if (stat.is_fill)
                begin
                    state_next = ST_FILL;
                end
                else if (stat.skip)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                cmd.walk = 1'b1;
                if (stat.walk_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL:
            begin
                cmd.sweep = 1'b1;
                if (stat.sweep_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign out_valid = out_valid_reg;

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid_reg && out_stall) |=> (state_reg == ST_DONE))
        else $error("Result overwrote an item still waiting at the output.");

    a_finish_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_valid_reg)
        else $error("Finished item did not reach the output register.");

    a_accept_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_START))
        else $error("Accepted item was not decoded.");

    a_fill_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_START && stat.is_fill) |=> (state_reg == ST_FILL))
        else $error("Fill request did not start a sweep.");

endmodule

`default_nettype wire

@@ design/bvre_datapath.sv @@
// ============================================================================
// Bit vector range engine datapath
// Holds the byte store, the request registers, the byte walk pointers, the
// per-byte mask and update logic, the accumulators and the result register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module bvre_datapath #(
    parameter int STORE_BITS = 1024
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [2:0]        op,
    input  wire logic [9:0]        start_req,
    input  wire logic [10:0]       length,
    input  wire logic              bit_value,
    input  wire bvre_pkg::dp_cmd_t cmd,
    output bvre_pkg::dp_stat_t     stat,
    output logic                   bit_read,
    output logic [10:0]            count,
    output logic [9:0]             index,
    output logic                   found,
    output logic                   range_error
);
    import bvre_pkg::*;

    localparam int STORE_BYTES = (STORE_BITS + 7) / 8;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int LIM_W       = $clog2(STORE_BITS + 1);
    localparam int IW          = (LIM_W > 12) ? LIM_W : 12;
    localparam logic [AW-1:0] LAST_BYTE = AW'(STORE_BYTES - 1);
    localparam logic [IW-1:0] LIMIT     = IW'(STORE_BITS);

    logic [7:0]    mem [STORE_BYTES];
    logic [7:0]    rd_data_reg;

    op_t           op_reg;
    logic          val_reg;
    logic [2:0]    start_lo_reg;
    logic [2:0]    end_lo_reg;
    logic [AW-1:0] fb_reg;
    logic [AW-1:0] lb_reg;
    logic          err_reg;
    logic          empty_reg;
    logic [AW-1:0] iss_reg;
    logic          iss_done_reg;
    logic [AW-1:0] prc_reg;
    logic          pv_reg;
    logic [AW-1:0] clr_reg;
    logic [10:0]   cnt_reg;
    logic [9:0]    idx_reg;
    logic          fnd_reg;
    logic          rbit_reg;

    logic          bit_read_reg;
    logic [10:0]   count_reg;
    logic [9:0]    index_reg;
    logic          found_reg;
    logic          range_error_reg;

    op_t           op_in;
    logic [10:0]   len_eff;
    logic [IW-1:0] start_ext;
    logic [IW-1:0] sum_idx;
    logic [IW-1:0] end_idx;
    logic          req_err;
    logic          req_empty;
    logic [AW-1:0] fb_in;
    logic [AW-1:0] lb_in;

    logic          backward;
    logic          search;
    logic [AW-1:0] final_byte;
    logic [2:0]    lo;
    logic [2:0]    hi;
    logic [7:0]    mask;
    logic [7:0]    match;
    logic          hit;
    logic [7:0]    wdata;
    logic          we;
    logic          proc;
    logic [2:0]    pos;
    logic [IW-1:0] hit_idx;

    assign op_in     = op_t'(op);
    assign len_eff   = (op_in == OP_READ) ? 11'd1 : length;
    assign start_ext = IW'(start_req);
    assign sum_idx   = start_ext + IW'(len_eff);
    assign end_idx   = sum_idx - IW'(1);
    assign req_err   = (op_in != OP_FILL) && (sum_idx > LIMIT);
    assign req_empty = (len_eff == 11'd0);
    assign fb_in     = start_ext[AW+2:3];
    assign lb_in     = end_idx[AW+2:3];

    assign backward   = (op_reg == OP_LAST);
    assign search     = (op_reg == OP_FIRST) || (op_reg == OP_LAST);
    assign final_byte = backward ? fb_reg : lb_reg;
    assign lo         = (prc_reg == fb_reg) ? start_lo_reg : 3'd0;
    assign hi         = (prc_reg == lb_reg) ? end_lo_reg : 3'd7;
    assign mask       = range_mask(lo, hi);
    assign match      = (val_reg ? rd_data_reg : ~rd_data_reg) & mask;
    assign hit        = (match != 8'h00);
    assign proc       = cmd.walk && pv_reg;
    assign pos        = backward ? last_pos(match) : first_pos(match);
    assign hit_idx    = IW'({prc_reg, pos});

    always_comb
    begin
        case (op_reg)
            OP_SET:  wdata = val_reg ? (rd_data_reg | mask) : (rd_data_reg & ~mask);
            OP_FLIP: wdata = rd_data_reg ^ mask;
            default: wdata = rd_data_reg;
        endcase
    end

    assign we = proc && ((op_reg == OP_SET) || (op_reg == OP_FLIP));

    assign stat.sweep_last = (clr_reg == LAST_BYTE);
    assign stat.is_fill    = (op_reg == OP_FILL);
    assign stat.skip       = err_reg || empty_reg;
    assign stat.walk_done  = pv_reg && ((prc_reg == final_byte) || (search && hit));

    always_ff @(posedge clk)
    begin
        if (cmd.sweep)
        begin
            mem[clr_reg] <= {8{val_reg}};
        end
        else if (we)
        begin
            mem[prc_reg] <= wdata;
        end
        rd_data_reg <= mem[iss_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg       <= OP_READ;
            val_reg      <= 1'b0;
            clr_reg      <= '0;
            pv_reg       <= 1'b0;
            iss_done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.sweep)
            begin
                clr_reg <= stat.sweep_last ? '0 : clr_reg + AW'(1);
            end
            if (cmd.load)
            begin
                op_reg       <= op_in;
                val_reg      <= bit_value;
                pv_reg       <= 1'b0;
                iss_done_reg <= 1'b0;
            end
            else
            begin
                pv_reg <= cmd.walk && !iss_done_reg;
                if (cmd.walk && !iss_done_reg && (iss_reg == final_byte))
                begin
                    iss_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            start_lo_reg <= start_ext[2:0];
            end_lo_reg   <= end_idx[2:0];
            fb_reg       <= fb_in;
            lb_reg       <= lb_in;
            err_reg      <= req_err;
            empty_reg    <= req_empty;
            iss_reg      <= (op_in == OP_LAST) ? lb_in : fb_in;
            cnt_reg      <= '0;
            idx_reg      <= '0;
            fnd_reg      <= 1'b0;
            rbit_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.walk && !iss_done_reg && (iss_reg != final_byte))
            begin
                iss_reg <= backward ? iss_reg - AW'(1) : iss_reg + AW'(1);
            end
            prc_reg <= iss_reg;
            if (proc)
            begin
                case (op_reg)
                    OP_READ:
                    begin
                        rbit_reg <= ((rd_data_reg & mask) != 8'h00);
                    end
                    OP_COUNT, OP_CONTAINS:
                    begin
                        cnt_reg <= cnt_reg + 11'(popcount8(match));
                    end
                    OP_FIRST, OP_LAST:
                    begin
                        if (hit)
                        begin
                            fnd_reg <= 1'b1;
                            idx_reg <= hit_idx[9:0];
                        end
                    end
                    default:
                    begin
                        rbit_reg <= rbit_reg;
                    end
                endcase
            end
        end
        if (cmd.finish)
        begin
            bit_read_reg    <= rbit_reg;
            count_reg       <= cnt_reg;
            index_reg       <= idx_reg;
            found_reg       <= (op_reg == OP_CONTAINS) ? (cnt_reg != 11'd0) : fnd_reg;
            range_error_reg <= err_reg;
        end
    end

    assign bit_read    = bit_read_reg;
    assign count       = count_reg;
    assign index       = index_reg;
    assign found       = found_reg;
    assign range_error = range_error_reg;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ============================================================================
// Bit vector range engine testbench
// Runs directed requests over field extremes, byte-boundary ranges, empty
// ranges, range errors and fills, then random requests with random idling on
// both channels. A bitmap predictor computes each expected result item when a
// request item is accepted, and the monitor compares every returned item
// field by field.
// ============================================================================

module tb;
    import bvre_pkg::*;

    localparam int STORE_BITS = 1024;
    localparam int RANDOM_ITEMS = 1075;
    localparam int QUIET_LO = 200;
    localparam int QUIET_HI = 450;
    localparam int HOLD_AT = 700;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_AT = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PRINT_CAP = 100;

    typedef struct packed {
        op_t         op;
        logic [9:0]  start;
        logic [10:0] span;
        logic        value;
        logic        drain_first;
    } request_t;

    typedef struct packed {
        logic        bit_read;
        logic [10:0] count;
        logic [9:0]  index;
        logic        found;
        logic        range_error;
    } result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  op = OP_READ;
    logic [9:0]  start_req = '0;
    logic [10:0] length = '0;
    logic        bit_value = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        bit_read;
    logic [10:0] count;
    logic [9:0]  index;
    logic        found;
    logic        range_error;

    logic     bitmap [0:STORE_BITS-1];
    request_t request_queue [$];
    result_t  pending_results [$];
    request_t on_bus;
    result_t  predicted;
    result_t  want;
    bit       offer;
    bit       stall_next;
    bit       hold_done = 1'b0;
    int       hold_left = 0;
    int       items_accepted = 0;
    int       results_seen = 0;
    int       mismatches = 0;
    int       errors_predicted = 0;
    int       hits_predicted = 0;
    int       quiet_cycles = 0;

    bit_vector_range_engine_unit #(
        .STORE_BITS(STORE_BITS)
    ) u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .op(op),
        .start_req(start_req),
        .length(length),
        .bit_value(bit_value),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .bit_read(bit_read),
        .count(count),
        .index(index),
        .found(found),
        .range_error(range_error)
    );

    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    function automatic result_t bitmap_apply(input request_t req);
        result_t res;
        int      lo;
        int      span;
        int      hits;
        res = '0;
        lo = int'(req.start);
        span = int'(req.span);
        hits = 0;
        if (req.op == OP_FILL)
        begin
            for (int n = 0; n < STORE_BITS; n++)
            begin
                bitmap[n] = req.value;
            end
        end
        else if (req.op == OP_READ)
        begin
            if (lo >= STORE_BITS)
            begin
                res.range_error = 1'b1;
            end
            else
            begin
                res.bit_read = bitmap[lo];
            end
        end
        else if (lo + span > STORE_BITS)
        begin
            res.range_error = 1'b1;
        end
        else
        begin
            case (req.op)
                OP_SET:
                begin
                    for (int n = lo; n < lo + span; n++)
                    begin
                        bitmap[n] = req.value;
                    end
                end
                OP_FLIP:
                begin
                    for (int n = lo; n < lo + span; n++)
                    begin
                        bitmap[n] = ~bitmap[n];
                    end
                end
                OP_COUNT, OP_CONTAINS:
                begin
                    for (int n = lo; n < lo + span; n++)
                    begin
                        if (bitmap[n] == req.value)
                        begin
                            hits++;
                        end
                    end
                    res.count = 11'(hits);
                    res.found = (req.op == OP_CONTAINS) && (hits > 0);
                end
                OP_FIRST:
                begin
                    for (int n = lo; n < lo + span; n++)
                    begin
                        if (!res.found && bitmap[n] == req.value)
                        begin
                            res.found = 1'b1;
                            res.index = 10'(n);
                        end
                    end
                end
                default:
                begin
                    for (int n = lo + span - 1; n >= lo; n--)
                    begin
                        if (!res.found && bitmap[n] == req.value)
                        begin
                            res.found = 1'b1;
                            res.index = 10'(n);
                        end
                    end
                end
            endcase
        end
        return res;
    endfunction

    task automatic add_request(input op_t kind, input int start, input int span,
                               input bit value, input bit drain_first);
        request_t req;
        req.op = kind;
        req.start = 10'(start);
        req.span = 11'(span);
        req.value = value;
        req.drain_first = drain_first;
        request_queue.push_back(req);
    endtask

    task automatic add_random_request(input bit drain_first);
        op_t kind;
        int  shape;
        int  start;
        int  span;
        if ($urandom_range(0, 99) < 3)
        begin
            kind = OP_FILL;
        end
        else
        begin
            kind = op_t'(3'($urandom_range(0, 6)));
        end
        start = $urandom_range(0, STORE_BITS - 1);
        shape = $urandom_range(0, 99);
        if (shape < 55)
        begin
            span = $urandom_range(1, 24);
        end
        else if (shape < 80)
        begin
            span = $urandom_range(25, 300);
        end
        else if (shape < 88)
        begin
            span = STORE_BITS - start + $urandom_range(0, 1);
        end
        else if (shape < 93)
        begin
            span = 0;
        end
        else
        begin
            span = $urandom_range(0, 2047);
        end
        add_request(kind, start, span, 1'($urandom_range(0, 1)), drain_first);
    endtask

    task automatic report_mismatch(input string what, input int got, input int exp_val);
        if (mismatches < PRINT_CAP)
        begin
            $display("MISMATCH result %0d: %s got %0d expected %0d",
                     results_seen, what, got, exp_val);
        end
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            op <= OP_READ;
            start_req <= '0;
            length <= '0;
            bit_value <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                predicted = bitmap_apply(on_bus);
                pending_results.push_back(predicted);
                items_accepted++;
                if (predicted.range_error)
                begin
                    errors_predicted++;
                end
                if (predicted.found)
                begin
                    hits_predicted++;
                end
            end
            if (!in_valid || !in_stall)
            begin
                offer = request_queue.size() > 0;
                if (offer && request_queue[0].drain_first && pending_results.size() > 0)
                begin
                    offer = 1'b0;
                end
                if (offer && !(items_accepted >= QUIET_LO && items_accepted < QUIET_HI)
                    && $urandom_range(0, 99) < 26)
                begin
                    offer = 1'b0;
                end
                if (offer)
                begin
                    on_bus = request_queue.pop_front();
                    op <= on_bus.op;
                    start_req <= on_bus.start;
                    length <= on_bus.span;
                    bit_value <= on_bus.value;
                end
                in_valid <= offer;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("unexpected result item", 1, 0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (bit_read !== want.bit_read)
                    begin
                        report_mismatch("bit_read", bit_read, want.bit_read);
                    end
                    if (count !== want.count)
                    begin
                        report_mismatch("count", count, want.count);
                    end
                    if (index !== want.index)
                    begin
                        report_mismatch("index", index, want.index);
                    end
                    if (found !== want.found)
                    begin
                        report_mismatch("found", found, want.found);
                    end
                    if (range_error !== want.range_error)
                    begin
                        report_mismatch("range_error", range_error, want.range_error);
                    end
                end
                results_seen++;
            end
            if (!hold_done && results_seen == HOLD_AT)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                stall_next = 1'b1;
            end
            else if (results_seen >= QUIET_LO && results_seen < QUIET_HI)
            begin
                stall_next = 1'b0;
            end
            else
            begin
                stall_next = $urandom_range(0, 99) < 26;
            end
            out_stall <= stall_next;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Timeout after %0d cycles with no item accepted.", quiet_cycles);
                $display("[bit_vector_range_engine_unit] ERROR");
                $finish;
            end
        end
    end

    initial
    begin
        for (int n = 0; n < STORE_BITS; n++)
        begin
            bitmap[n] = 1'b0;
        end

        add_request(OP_READ, 0, 0, 1'b0, 1'b0);
        add_request(OP_READ, 1023, 2047, 1'b1, 1'b0);
        add_request(OP_FILL, 1023, 2047, 1'b1, 1'b0);
        add_request(OP_READ, 1023, 1, 1'b0, 1'b0);
        add_request(OP_COUNT, 0, 1024, 1'b1, 1'b0);
        add_request(OP_SET, 0, 1024, 1'b0, 1'b0);
        add_request(OP_SET, 3, 10, 1'b1, 1'b0);
        add_request(OP_FLIP, 5, 16, 1'b0, 1'b0);
        add_request(OP_SET, 9, 3, 1'b0, 1'b0);
        add_request(OP_COUNT, 0, 0, 1'b1, 1'b0);
        add_request(OP_CONTAINS, 0, 64, 1'b1, 1'b0);
        add_request(OP_CONTAINS, 64, 64, 1'b0, 1'b0);
        add_request(OP_FIRST, 0, 1024, 1'b1, 1'b0);
        add_request(OP_LAST, 0, 1024, 1'b1, 1'b0);
        add_request(OP_FIRST, 100, 50, 1'b1, 1'b0);
        add_request(OP_LAST, 0, 30, 1'b0, 1'b0);
        add_request(OP_SET, 1000, 25, 1'b1, 1'b0);
        add_request(OP_COUNT, 1023, 2047, 1'b0, 1'b0);
        add_request(OP_FLIP, 0, 1025, 1'b0, 1'b0);
        add_request(OP_FLIP, 1023, 1, 1'b0, 1'b0);
        add_request(OP_SET, 1000, 24, 1'b1, 1'b0);
        add_request(OP_FLIP, 0, 1024, 1'b1, 1'b0);
        add_request(OP_FIRST, 1000, 24, 1'b0, 1'b0);
        add_request(OP_FILL, 0, 0, 1'b0, 1'b1);
        add_request(OP_LAST, 0, 1024, 1'b1, 1'b0);
        for (int k = 0; k < RANDOM_ITEMS; k++)
        begin
            add_random_request(k == DRAIN_AT || $urandom_range(0, 99) == 0);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (request_queue.size() != 0 || in_valid || pending_results.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (200) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            report_mismatch("results never returned", pending_results.size(), 0);
        end

        $display("Ran %0d request items through all eight operations with random idling.",
                 items_accepted);
        $display("Saw %0d result items, %0d range errors and %0d found flags.",
                 results_seen, errors_predicted, hits_predicted);
        if (mismatches == 0)
        begin
            $display("[bit_vector_range_engine_unit] OK");
        end
        else
        begin
            $display("%0d mismatches.", mismatches);
            $display("[bit_vector_range_engine_unit] ERROR");
        end
        $finish;
    end

endmodule
